### sv/srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the sorted record table
// Beat structs, operation and status codes, and the engine state type.
// ----------------------------------------------------------------------------
package srt_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ENTRY = 2'd3
    } status_t;

    localparam int CNT_W = 6;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] rec_key;
        logic signed [31:0] rec_score;
        logic [63:0]        name_bytes_a;
        logic [63:0]        name_bytes_b;
        logic [31:0]        name_bytes_c;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_score;
        logic [63:0]        out_name_a;
        logic [63:0]        out_name_b;
        logic [31:0]        out_name_c;
        logic [CNT_W-1:0]   entries_held;
        logic [CNT_W-1:0]   removed_count;
        logic               last;
    } out_beat_t;

    // One stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] score;
        logic [63:0]        name_a;
        logic [63:0]        name_b;
        logic [31:0]        name_c;
    } entry_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SEARCH,
        ENG_SHIFT,
        ENG_DELETE,
        ENG_DUMP,
        ENG_EMIT
    } eng_state_t;

endpackage

### sv/srt_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_cmd_queue: two-entry command queue
// Parts the accepting front from the table engine.
// ----------------------------------------------------------------------------
module srt_cmd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srt_pkg::in_beat_t push_data,
    output logic             full,
    input  logic             pop,
    output srt_pkg::in_beat_t pop_data,
    output logic             empty
);
    import srt_pkg::*;

    in_beat_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
        end
    end

endmodule

### sv/srt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_engine: table engine
// Walks the record memory entry by entry for insert, delete and dump.
// ----------------------------------------------------------------------------
module srt_engine #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  srt_pkg::in_beat_t cmd,
    output logic              cmd_take,
    output logic              res_valid,
    output srt_pkg::out_beat_t res,
    input  logic              res_take
);
    import srt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];

    eng_state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;   // read index
    logic [CW-1:0]   kept_reg, kept_next; // delete write index / shift index
    in_beat_t        cmd_reg;
    logic            rd_valid_reg, rd_valid_next;
    entry_t          rd_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic            res_valid_reg;
    out_beat_t       res_reg, res_next;
    logic            res_load;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t          wr_data;
    logic            rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic            space;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign space     = !res_valid_reg || res_take;

    // Record memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    function automatic out_beat_t mk_res(logic [1:0] st, entry_t e, logic use_e,
                                         logic [CW-1:0] held, logic [CW-1:0] rem,
                                         logic lst);
        out_beat_t r;
        r.status        = st;
        r.out_key       = use_e ? e.key : '0;
        r.out_score     = use_e ? e.score : '0;
        r.out_name_a    = use_e ? e.name_a : '0;
        r.out_name_b    = use_e ? e.name_b : '0;
        r.out_name_c    = use_e ? e.name_c : '0;
        r.entries_held  = CNT_W'(held);
        r.removed_count = CNT_W'(rem);
        r.last          = lst;
        return r;
    endfunction

    // Next state and datapath control
    always_comb
    begin
        entry_t ne;
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        kept_next     = kept_reg;
        rd_valid_next = 1'b0;
        cmd_take      = 1'b0;
        res_load      = 1'b0;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = rd_reg;
        rd_en         = 1'b0;
        rd_addr       = IDX_W'(ptr_reg);
        ne.key        = cmd_reg.rec_key;
        ne.score      = cmd_reg.rec_score;
        ne.name_a     = cmd_reg.name_bytes_a;
        ne.name_b     = cmd_reg.name_bytes_b;
        ne.name_c     = cmd_reg.name_bytes_c;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (cmd_valid && space)
                begin
                    cmd_take = 1'b1;
                    ptr_next = '0;
                    kept_next = '0;
                    unique case (mode_t'(cmd.mode))
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            res_load = 1'b1;
                            res_next = mk_res(ST_OK, ne, 1'b0, '0, '0, 1'b1);
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg >= CW'(TABLE_DEPTH))
                            begin
                                res_load = 1'b1;
                                res_next = mk_res(ST_FULL, ne, 1'b0, count_reg, '0, 1'b1);
                            end
                            else
                            begin
                                state_next = ENG_SEARCH;
                            end
                        end
                        MODE_DELETE: state_next = ENG_DELETE;
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load = 1'b1;
                                res_next = mk_res(ST_EMPTY, ne, 1'b0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                state_next = ENG_DUMP;
                            end
                        end
                    endcase
                end
            end
            ENG_SEARCH:
            begin
                // Issue reads at ptr; compare the previous read
                if (rd_valid_reg && (rd_reg.key >= cmd_reg.rec_key))
                begin
                    kept_next  = count_reg;
                    ptr_next   = rd_idx_reg;
                    state_next = ENG_SHIFT;
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    kept_next  = count_reg;
                    ptr_next   = count_reg;
                    state_next = ENG_SHIFT;
                end
            end
            ENG_SHIFT:
            begin
                // kept = write slot, ptr = insert position; read kept-1 then write
                if (rd_valid_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = IDX_W'(kept_reg);
                    kept_next = kept_reg - 1'b1;
                end
                else if (kept_reg > ptr_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = IDX_W'(kept_reg - 1'b1);
                    rd_valid_next = 1'b1;
                end
                else if (space)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = IDX_W'(ptr_reg);
                    wr_data    = ne;
                    count_next = count_reg + 1'b1;
                    res_load   = 1'b1;
                    res_next   = mk_res(ST_OK, ne, 1'b0, count_reg + 1'b1, '0, 1'b1);
                    state_next = ENG_IDLE;
                end
            end
            ENG_DELETE:
            begin
                // Compact: keep entries whose key differs
                if (rd_valid_reg && (rd_reg.key != cmd_reg.rec_key))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = IDX_W'(kept_reg);
                    kept_next = kept_reg + 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    ptr_next      = ptr_reg + 1'b1;
                end
                else if (!rd_valid_reg && space)
                begin
                    count_next = kept_reg;
                    res_load   = 1'b1;
                    res_next   = mk_res(ST_OK, ne, 1'b0, kept_reg, count_reg - kept_reg,
                                        1'b1);
                    state_next = ENG_IDLE;
                end
            end
            ENG_DUMP:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                ptr_next      = ptr_reg + 1'b1;
                state_next    = ENG_EMIT;
            end
            ENG_EMIT:
            begin
                if (space)
                begin
                    res_load = 1'b1;
                    res_next = mk_res(ST_ENTRY, rd_reg, 1'b1, count_reg, '0,
                                      ptr_reg == count_reg);
                    state_next = (ptr_reg == count_reg) ? ENG_IDLE : ENG_DUMP;
                end
                else
                begin
                    rd_valid_next = rd_valid_reg;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            kept_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            kept_reg     <= kept_next;
            rd_valid_reg <= rd_valid_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (rd_en)
        begin
            rd_idx_reg <= ptr_reg;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### sv/sorted_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table: key-ordered record table
// Channel   Handshake      Beat
// input     push / full    in_beat  (mode, key, score, name)
// result    pop / empty    out_beat (status, entry, counts, last)
// Insert and delete walk the N entries held in the record memory through its
// one write and one registered read port. Dump gives one beat per entry held,
// the last one flagged; clear and rejects give a single beat without a walk.
// Commands queue two deep ahead of the engine. Reset empties the table; no
// clearing pass. A stalled result holds the engine, but up to two commands
// are still taken.
// ----------------------------------------------------------------------------
module sorted_record_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srt_pkg::in_beat_t  in_beat,
    output logic               full,
    input  logic               pop,
    output srt_pkg::out_beat_t out_beat,
    output logic               empty
);
    import srt_pkg::*;

    in_beat_t q_data;
    logic     q_empty, q_take, res_valid;

    srt_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_beat),
        .full      (full),
        .pop       (q_take),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    srt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_data),
        .cmd_take  (q_take),
        .res_valid (res_valid),
        .res       (out_beat),
        .res_take  (pop && res_valid)
    );

    assign empty = !res_valid;

endmodule

### tb/sorted_record_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table_tb: self-checking bench for the sorted record table
// Drives clear, insert, delete and dump beats, keeps a model of the ordered
// table in a scoreboard class and checks every result beat field by field.
// Idling phases vary on both sides, with one long result hold-off.
// ----------------------------------------------------------------------------
module sorted_record_table_tb;
    import srt_pkg::*;

    localparam int DEPTH = 32;

    // Ordered table model and queue of expected result beats
    class table_scoreboard;
        entry_t    rows[$];
        out_beat_t pending[$];
        int        mismatches;
        int        checked;

        function out_beat_t plain_beat(status_t st, int removed);
            out_beat_t b;
            b = '0;
            b.status = st;
            b.entries_held = CNT_W'(rows.size());
            b.removed_count = CNT_W'(removed);
            b.last = 1'b1;
            return b;
        endfunction

        function void note_command(in_beat_t cmd);
            entry_t    e;
            out_beat_t b;
            int        pos;
            int        before_n;
            case (mode_t'(cmd.mode))
                MODE_CLEAR:
                begin
                    rows.delete();
                    pending.push_back(plain_beat(ST_OK, 0));
                end
                MODE_INSERT:
                begin
                    if (rows.size() >= DEPTH)
                        pending.push_back(plain_beat(ST_FULL, 0));
                    else
                    begin
                        e.key = cmd.rec_key;
                        e.score = cmd.rec_score;
                        e.name_a = cmd.name_bytes_a;
                        e.name_b = cmd.name_bytes_b;
                        e.name_c = cmd.name_bytes_c;
                        pos = 0;
                        while (pos < rows.size() && rows[pos].key < cmd.rec_key)
                            pos++;
                        rows.insert(pos, e);
                        pending.push_back(plain_beat(ST_OK, 0));
                    end
                end
                MODE_DELETE:
                begin
                    before_n = rows.size();
                    for (int i = rows.size() - 1; i >= 0; i--)
                        if (rows[i].key == cmd.rec_key)
                            rows.delete(i);
                    pending.push_back(plain_beat(ST_OK, before_n - rows.size()));
                end
                default:
                begin
                    if (rows.size() == 0)
                        pending.push_back(plain_beat(ST_EMPTY, 0));
                    else
                        foreach (rows[i])
                        begin
                            b = plain_beat(ST_ENTRY, 0);
                            b.out_key = rows[i].key;
                            b.out_score = rows[i].score;
                            b.out_name_a = rows[i].name_a;
                            b.out_name_b = rows[i].name_b;
                            b.out_name_c = rows[i].name_c;
                            b.last = (i == rows.size() - 1);
                            pending.push_back(b);
                        end
                end
            endcase
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %h", $realtime, got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  exp st=%0d k=%0d s=%0d n=%h_%h_%h held=%0d rm=%0d last=%0d",
                        want.status, want.out_key, want.out_score,
                        want.out_name_c, want.out_name_b, want.out_name_a,
                        want.entries_held, want.removed_count, want.last);
                    $display("  got st=%0d k=%0d s=%0d n=%h_%h_%h held=%0d rm=%0d last=%0d",
                        got.status, got.out_key, got.out_score,
                        got.out_name_c, got.out_name_b, got.out_name_a,
                        got.entries_held, got.removed_count, got.last);
                end
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    in_beat_t  in_beat;
    logic      full;
    logic      pop;
    out_beat_t out_beat;
    logic      empty;

    table_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  sent;
    int  key_pool[8];

    sorted_record_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .in_beat(in_beat), .full(full),
        .pop(pop), .out_beat(out_beat), .empty(empty)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Accepted beats go to the scoreboard at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            sb.note_command(in_beat);
        if (rst_n && pop && !empty)
            sb.check_result(out_beat);
    end

    // Receiver: random stalls, plus a counted hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one command beat and wait until it is taken; push stays high
    // so that the next beat can follow straight on
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    function automatic in_beat_t make_cmd(mode_t m, logic [31:0] k);
        in_beat_t b;
        b.mode = m;
        b.rec_key = k;
        b.rec_score = $urandom;
        b.name_bytes_a = {$urandom, $urandom};
        b.name_bytes_b = {$urandom, $urandom};
        b.name_bytes_c = $urandom;
        return b;
    endfunction

    // Keys mostly from a small pool so that equal keys and deletes hit
    function automatic logic [31:0] pick_key();
        if ($urandom_range(3) == 0)
            return $urandom;
        return key_pool[$urandom_range(7)];
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        in_beat_t b;
        int       r;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        in_beat = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        sent = 0;
        key_pool = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 5, 5, 100};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty dump, extremes, equal keys, absent delete, clear
        send_beat(make_cmd(MODE_DUMP, 0));
        send_beat(make_cmd(MODE_DELETE, 7));
        b = make_cmd(MODE_INSERT, 32'sh7fffffff);
        b.rec_score = 32'sh80000000;
        b.name_bytes_a = '1;
        b.name_bytes_b = '1;
        b.name_bytes_c = '1;
        send_beat(b);
        b = make_cmd(MODE_INSERT, 32'sh80000000);
        b.rec_score = 32'sh7fffffff;
        b.name_bytes_a = '0;
        b.name_bytes_b = '0;
        b.name_bytes_c = '0;
        send_beat(b);
        send_beat(make_cmd(MODE_INSERT, 5));
        send_beat(make_cmd(MODE_INSERT, 5));
        send_beat(make_cmd(MODE_INSERT, 0));
        send_beat(make_cmd(MODE_DUMP, 0));
        send_beat(make_cmd(MODE_DELETE, 5));
        send_beat(make_cmd(MODE_DELETE, 12345));
        send_beat(make_cmd(MODE_DUMP, 0));
        send_beat(make_cmd(MODE_CLEAR, 0));
        send_beat(make_cmd(MODE_DUMP, 0));
        // Fill past capacity to see rejects, then dump a full table
        for (int i = 0; i < DEPTH + 2; i++)
            send_beat(make_cmd(MODE_INSERT, pick_key()));
        send_beat(make_cmd(MODE_DUMP, 0));
        send_beat(make_cmd(MODE_DELETE, 5));

        // Long result hold-off while commands keep coming
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_beat(make_cmd(MODE_DUMP, 0));
        drain();

        // Random phases with varying idling on each side
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 37) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 37) : 0;
            for (int i = 0; i < 110; i++)
            begin
                r = $urandom_range(99);
                if (r < 2)
                    send_beat(make_cmd(MODE_CLEAR, $urandom));
                else if (r < 62)
                    send_beat(make_cmd(MODE_INSERT, pick_key()));
                else if (r < 82)
                    send_beat(make_cmd(MODE_DELETE, pick_key()));
                else
                    send_beat(make_cmd(MODE_DUMP, $urandom));
            end
            drain();
        end

        $display("Sent %0d command beats, checked %0d result beats", sent, sb.checked);
        $display("Covered clear, ordered insert with rejects, delete and dump under stalls");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sorted_record_table_tb: clean");
        else
        begin
            $display("%0d mismatches, %0d beats outstanding", sb.mismatches,
                     sb.pending.size());
            $display("sorted_record_table_tb: errors");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("sorted_record_table_tb: errors");
        $finish;
    end

endmodule
